[hdl/pws_pkg.sv]
// Shared types and constants of the protocol-buffer wire scanner.
package pws_pkg;

  // A varint that still carries the continuation bit after this many bytes
  // is cut off and reads as zero.
  localparam int unsigned MAX_VARINT_BYTES = 9;
  localparam int unsigned SHIFT_W          = 4;
  localparam int unsigned FIXED32_BYTES    = 4;
  localparam int unsigned SKIP64_BYTES     = 8;

  // Token queue between the parser and the output stage.
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QUEUE_AW    = $clog2(QUEUE_DEPTH);
  localparam int unsigned QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic [7:0] in_byte;
    logic       last_byte;
  } pws_in_t;

  typedef struct packed {
    logic [2:0]  token_kind;
    logic [28:0] field_id;
    logic [2:0]  wire_code;
    logic [63:0] field_value;
    logic [7:0]  payload_byte;
    logic        payload_end;
    logic        message_end;
  } pws_out_t;

endpackage

[hdl/protobuf_wire_scanner_core.sv]
// Top level of the protocol-buffer wire scanner: parser, token queue, output stage.
//
//   channel   direction  handshake                 payload
//   input     in         in_valid_i / in_stall_o   in_data_i  (pws_in_t: byte, last flag)
//   output    out        out_valid_o / out_stall_i out_data_o (pws_out_t: one token)
//
// The parser takes one message byte per cycle unless in_stall_o is high; the whole
// per-byte step (varint merge, phase change and the 64-bit payload countdown) is one
// register stage. A token passes from the queue entry, written at the edge that takes
// its byte, to the output register, which loads once it is empty or its token leaves.
// Reset is asynchronous and active low; it returns the parser to the tag phase and
// empties the queue and the output register. No clearing pass is needed.
// The two-entry queue lets input keep flowing while a token waits downstream; input
// is stalled only while that queue is full.
module protobuf_wire_scanner_core import pws_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  pws_in_t  in_data_i,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output pws_out_t out_data_o
);

  logic     queue_full;
  logic     queue_empty;
  logic     push;
  logic     pop;
  pws_out_t token;
  pws_out_t queue_head;

  // The parser classifies each byte and forms at most one token per transaction.
  pws_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_data_i    (in_data_i),
    .queue_full_i (queue_full),
    .in_stall_o   (in_stall_o),
    .push_o       (push),
    .token_o      (token)
  );

  // Tokens wait here so that the parser and the consumer stall independently.
  pws_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (token),
    .full_o  (queue_full),
    .pop_i   (pop),
    .data_o  (queue_head),
    .empty_o (queue_empty)
  );

  // The output register presents one token per transaction on the result channel.
  pws_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .empty_i     (queue_empty),
    .data_i      (queue_head),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

[hdl/pws_front.sv]
// Byte parser: walks the wire format one byte per transaction and builds tokens.
module pws_front import pws_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  input  pws_in_t  in_data_i,
  input  logic     queue_full_i,
  output logic     in_stall_o,
  output logic     push_o,
  output pws_out_t token_o
);

  typedef enum logic [2:0] {
    PH_TAG     = 3'd0,
    PH_VARINT  = 3'd1,
    PH_FIXED32 = 3'd2,
    PH_SKIP64  = 3'd3,
    PH_LENGTH  = 3'd4,
    PH_PAYLOAD = 3'd5,
    PH_CORRUPT = 3'd6
  } phase_e;

  typedef enum logic [2:0] {
    TK_VARINT    = 3'd0,
    TK_FIXED32   = 3'd1,
    TK_LENGTH    = 3'd2,
    TK_PAYLOAD   = 3'd3,
    TK_SKIP64    = 3'd4,
    TK_CORRUPT   = 3'd5,
    TK_TRUNCATED = 3'd6
  } kind_e;

  localparam logic [2:0] WT_VARINT  = 3'd0;
  localparam logic [2:0] WT_FIXED64 = 3'd1;
  localparam logic [2:0] WT_LENDELIM = 3'd2;
  localparam logic [2:0] WT_FIXED32 = 3'd5;

  phase_e               phase_q, phase_d;
  logic [63:0]          accum_q, accum_d;
  logic [SHIFT_W-1:0]   shift_q, shift_d;
  logic [28:0]          field_q, field_d;
  logic [2:0]           wt_q, wt_d;
  logic [63:0]          rem_q, rem_d;
  logic [31:0]          fixed_q, fixed_d;

  logic                 in_acc;
  logic [6:0]           vsh;
  logic [63:0]          accum_new;
  logic [SHIFT_W-1:0]   shift_inc;
  logic                 vdone;
  logic [63:0]          vval;
  logic [31:0]          fixed_new;

  logic                 tok_valid;
  kind_e                kind;
  logic [63:0]          value;
  logic [7:0]           pbyte;
  logic                 pend;
  logic                 mid;

  assign in_stall_o = queue_full_i;
  assign in_acc     = in_valid_i && !queue_full_i;

  // Shared varint step: merge seven data bits at the current byte position.
  always_comb begin
    vsh       = 7'(shift_q) * 7'd7;
    accum_new = (vsh < 7'd64) ? (accum_q | (64'(in_data_i.in_byte[6:0]) << vsh[5:0]))
                              : accum_q;
    shift_inc = shift_q + SHIFT_W'(1);
    vdone     = !in_data_i.in_byte[7] || (shift_inc >= SHIFT_W'(MAX_VARINT_BYTES));
    vval      = in_data_i.in_byte[7] ? 64'd0 : accum_new;
    fixed_new = fixed_q | (32'(in_data_i.in_byte) << {shift_q[1:0], 3'b000});
  end

  always_comb begin
    phase_d   = phase_q;
    accum_d   = accum_q;
    shift_d   = shift_q;
    field_d   = field_q;
    wt_d      = wt_q;
    rem_d     = rem_q;
    fixed_d   = fixed_q;
    tok_valid = 1'b0;
    kind      = TK_VARINT;
    value     = 64'd0;
    pbyte     = 8'd0;
    pend      = 1'b0;
    mid       = 1'b0;

    if (phase_q == PH_TAG || phase_q == PH_VARINT || phase_q == PH_LENGTH) begin
      accum_d = vdone ? 64'd0 : accum_new;
      shift_d = vdone ? '0 : shift_inc;
    end

    case (phase_q)
      PH_TAG: begin
        if (vdone) begin
          field_d = vval[31:3];
          wt_d    = vval[2:0];
          case (vval[2:0])
            WT_VARINT:   phase_d = PH_VARINT;
            WT_FIXED64:  phase_d = PH_SKIP64;
            WT_LENDELIM: phase_d = PH_LENGTH;
            WT_FIXED32: begin
              phase_d = PH_FIXED32;
              fixed_d = 32'd0;
            end
            default: begin
              phase_d   = PH_CORRUPT;
              tok_valid = 1'b1;
              kind      = TK_CORRUPT;
            end
          endcase
        end
      end
      PH_VARINT: begin
        if (vdone) begin
          tok_valid = 1'b1;
          kind      = TK_VARINT;
          value     = vval;
          phase_d   = PH_TAG;
        end
      end
      PH_LENGTH: begin
        if (vdone) begin
          tok_valid = 1'b1;
          kind      = TK_LENGTH;
          value     = vval;
          rem_d     = vval;
          phase_d   = (vval == 64'd0) ? PH_TAG : PH_PAYLOAD;
        end
      end
      PH_FIXED32: begin
        if (shift_inc >= SHIFT_W'(FIXED32_BYTES)) begin
          tok_valid = 1'b1;
          kind      = TK_FIXED32;
          value     = {32'd0, fixed_new};
          fixed_d   = 32'd0;
          shift_d   = '0;
          phase_d   = PH_TAG;
        end else begin
          fixed_d = fixed_new;
          shift_d = shift_inc;
        end
      end
      PH_SKIP64: begin
        if (shift_inc >= SHIFT_W'(SKIP64_BYTES)) begin
          tok_valid = 1'b1;
          kind      = TK_SKIP64;
          shift_d   = '0;
          phase_d   = PH_TAG;
        end else begin
          shift_d = shift_inc;
        end
      end
      PH_PAYLOAD: begin
        rem_d     = rem_q - 64'd1;
        tok_valid = 1'b1;
        kind      = TK_PAYLOAD;
        pbyte     = in_data_i.in_byte;
        pend      = (rem_q == 64'd1);
        if (rem_q == 64'd1) begin
          phase_d = PH_TAG;
        end
      end
      PH_CORRUPT: begin
      end
      default: begin
        phase_d = PH_TAG;
        accum_d = 64'd0;
        shift_d = '0;
      end
    endcase

    // A message that stops inside a tag, value or payload reports truncation.
    if (in_data_i.last_byte) begin
      mid = (phase_d == PH_TAG) ? (shift_d != '0) : (phase_d != PH_CORRUPT);
      if (mid) begin
        tok_valid = 1'b1;
        kind      = TK_TRUNCATED;
        value     = 64'd0;
        pbyte     = 8'd0;
        pend      = 1'b0;
        if (phase_d == PH_TAG) begin
          field_d = 29'd0;
          wt_d    = 3'd0;
        end
      end
    end
  end

  always_comb begin
    token_o.token_kind   = kind;
    token_o.field_id     = field_d;
    token_o.wire_code    = wt_d;
    token_o.field_value  = value;
    token_o.payload_byte = pbyte;
    token_o.payload_end  = pend;
    token_o.message_end  = in_data_i.last_byte;
    push_o               = in_acc && tok_valid;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_TAG;
      accum_q <= 64'd0;
      shift_q <= '0;
      field_q <= 29'd0;
      wt_q    <= 3'd0;
      rem_q   <= 64'd0;
      fixed_q <= 32'd0;
    end else if (in_acc) begin
      if (in_data_i.last_byte) begin
        phase_q <= PH_TAG;
        accum_q <= 64'd0;
        shift_q <= '0;
        field_q <= 29'd0;
        wt_q    <= 3'd0;
        rem_q   <= 64'd0;
        fixed_q <= 32'd0;
      end else begin
        phase_q <= phase_d;
        accum_q <= accum_d;
        shift_q <= shift_d;
        field_q <= field_d;
        wt_q    <= wt_d;
        rem_q   <= rem_d;
        fixed_q <= fixed_d;
      end
    end
  end

`ifndef SYNTHESIS
  a_last_resets: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && in_data_i.last_byte |=> phase_q == PH_TAG && shift_q == '0)
    else $error("scanner state not cleared after final byte");

  a_payload_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_PAYLOAD |-> rem_q != 64'd0)
    else $error("payload phase with no bytes remaining");

  a_truncated_at_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o && token_o.token_kind == TK_TRUNCATED |-> token_o.message_end)
    else $error("truncated token on a byte that does not end the message");
`endif

endmodule

[hdl/pws_fifo.sv]
// Short token queue that decouples the parser from the output stage.
module pws_fifo import pws_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_i,
  input  pws_out_t data_i,
  output logic     full_o,
  input  logic     pop_i,
  output pws_out_t data_o,
  output logic     empty_o
);

  pws_out_t              mem_q [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [QUEUE_CW-1:0]   count_q;

  assign full_o  = (count_q == QUEUE_CW'(QUEUE_DEPTH));
  assign empty_o = (count_q == '0);
  assign data_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + QUEUE_AW'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + QUEUE_AW'(1);
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + QUEUE_CW'(1);
      end else if (pop_i && !push_i) begin
        count_q <= count_q - QUEUE_CW'(1);
      end
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o)
    else $error("token pushed into a full queue");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o)
    else $error("token popped from an empty queue");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= QUEUE_CW'(QUEUE_DEPTH))
    else $error("queue count beyond its depth");
`endif

endmodule

[hdl/pws_back.sv]
// Output stage: drains the token queue into a registered result channel.
module pws_back import pws_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     empty_i,
  input  pws_out_t data_i,
  output logic     pop_o,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output pws_out_t out_data_o
);

  logic     out_valid_q;
  pws_out_t out_data_q;

  // The register can load when it is empty or its token leaves this cycle.
  assign pop_o       = !empty_i && (!out_valid_q || !out_stall_i);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (pop_o) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      out_data_q <= data_i;
    end
  end

endmodule

[test/tb_protobuf_wire_scanner_core.sv]
// Self-checking testbench for the protocol-buffer wire scanner core.
module tb_protobuf_wire_scanner_core;
  import pws_pkg::*;

  // The random part stops once about this many bytes, not counting the ones
  // swallowed after a corrupt tag, have been accepted.
  localparam int unsigned RANDOM_ITEMS = 400;
  // The block holds tokens only in its queue and its output register; the drain pause
  // only has to outlast one worst-case receiver stall.
  localparam int unsigned DRAIN_CYCLES = 50;
  localparam int unsigned LONG_HOLD_CYCLES = 200;

  typedef enum logic [2:0] {
    TK_VARINT, TK_FIXED32, TK_LENGTH, TK_PAYLOAD, TK_SKIP64, TK_CORRUPT, TK_TRUNCATED
  } token_kind_e;

  // Wire types as carried in the low three bits of a tag.
  localparam logic [2:0] WT_VARINT = 3'd0;
  localparam logic [2:0] WT_I64    = 3'd1;
  localparam logic [2:0] WT_LEN    = 3'd2;
  localparam logic [2:0] WT_SGROUP = 3'd3;
  localparam logic [2:0] WT_EGROUP = 3'd4;
  localparam logic [2:0] WT_I32    = 3'd5;
  localparam logic [2:0] WT_RES6   = 3'd6;
  localparam logic [2:0] WT_RES7   = 3'd7;

  typedef enum logic [2:0] {
    SCAN_TAG, SCAN_VARINT, SCAN_FIXED32, SCAN_SKIP64, SCAN_LENGTH, SCAN_PAYLOAD, SCAN_CORRUPT
  } scan_phase_e;

  // One row of the directed table. Typed rows carry their token (or its absence)
  // written out by hand; the other rows are checked against the scanner model.
  typedef struct {
    logic [7:0] data;
    bit         last;
    bit         typed;
    bit         has_tok;
    pws_out_t   tok;
  } dir_row_t;

  logic     clk_i;
  logic     rst_ni;
  logic     in_valid_i;
  logic     in_stall_o;
  pws_in_t  in_data_i;
  logic     out_valid_o;
  logic     out_stall_i;
  pws_out_t out_data_o;

  // Scanner model state, one level of the wire format.
  scan_phase_e scan_phase;
  logic [63:0] varint_acc;
  int unsigned varint_bytes;
  logic [28:0] cur_field;
  logic [2:0]  cur_wire;
  logic [63:0] payload_left;
  logic [31:0] fixed_acc;

  pws_out_t    expected_tokens[$];
  logic [7:0]  msg_bytes[$];
  dir_row_t    dir_table[$];
  int unsigned mismatch_count = 0;
  int unsigned random_items = 0;
  bit          tx_idle = 1'b1;
  bit          rx_idle = 1'b1;
  bit          long_hold_req = 1'b0;

  protobuf_wire_scanner_core DUT (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_stall_o,
    .in_data_i,
    .out_valid_o,
    .out_stall_i,
    .out_data_o
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  function automatic void clear_scanner();
    scan_phase   = SCAN_TAG;
    varint_acc   = '0;
    varint_bytes = 0;
    cur_field    = '0;
    cur_wire     = '0;
    payload_left = '0;
    fixed_acc    = '0;
  endfunction

  // Adds one byte to the varint being read. Returns 1 once it is complete; a
  // varint that still continues after MAX_VARINT_BYTES bytes completes as zero.
  function automatic bit merge_varint(input logic [7:0] b, output logic [63:0] v);
    v = '0;
    if (varint_bytes * 7 < 64) varint_acc |= 64'(b[6:0]) << (varint_bytes * 7);
    if (!b[7]) begin
      v = varint_acc;
      varint_acc = '0;
      varint_bytes = 0;
      return 1'b1;
    end
    varint_bytes++;
    if (varint_bytes >= MAX_VARINT_BYTES) begin
      varint_acc = '0;
      varint_bytes = 0;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // Steps the scanner model by one accepted byte. Returns 1 when the byte
  // produces a token, which is then left in tok.
  function automatic bit predict_token(input logic [7:0] b, input bit last,
                                       output pws_out_t tok);
    logic [63:0] v;
    bit          emit;
    token_kind_e kind;
    logic [63:0] value;
    logic [7:0]  pbyte;
    bit          pend;
    bit          mid;
    emit  = 1'b0;
    kind  = TK_VARINT;
    value = '0;
    pbyte = '0;
    pend  = 1'b0;
    case (scan_phase)
      SCAN_TAG: begin
        if (merge_varint(b, v)) begin
          cur_field = v[31:3];
          cur_wire  = v[2:0];
          case (cur_wire)
            WT_VARINT: scan_phase = SCAN_VARINT;
            WT_I64:    scan_phase = SCAN_SKIP64;
            WT_LEN:    scan_phase = SCAN_LENGTH;
            WT_I32: begin
              scan_phase = SCAN_FIXED32;
              fixed_acc  = '0;
            end
            default: begin
              scan_phase = SCAN_CORRUPT;
              emit = 1'b1;
              kind = TK_CORRUPT;
            end
          endcase
        end
      end
      SCAN_VARINT: begin
        if (merge_varint(b, v)) begin
          emit  = 1'b1;
          kind  = TK_VARINT;
          value = v;
          scan_phase = SCAN_TAG;
        end
      end
      SCAN_LENGTH: begin
        if (merge_varint(b, v)) begin
          emit  = 1'b1;
          kind  = TK_LENGTH;
          value = v;
          payload_left = v;
          scan_phase = (v == 0) ? SCAN_TAG : SCAN_PAYLOAD;
        end
      end
      SCAN_FIXED32: begin
        fixed_acc |= 32'(b) << (8 * (varint_bytes % 4));
        varint_bytes++;
        if (varint_bytes >= FIXED32_BYTES) begin
          emit  = 1'b1;
          kind  = TK_FIXED32;
          value = 64'(fixed_acc);
          fixed_acc = '0;
          varint_bytes = 0;
          scan_phase = SCAN_TAG;
        end
      end
      SCAN_SKIP64: begin
        varint_bytes++;
        if (varint_bytes >= SKIP64_BYTES) begin
          emit = 1'b1;
          kind = TK_SKIP64;
          varint_bytes = 0;
          scan_phase = SCAN_TAG;
        end
      end
      SCAN_PAYLOAD: begin
        payload_left--;
        emit  = 1'b1;
        kind  = TK_PAYLOAD;
        pbyte = b;
        pend  = (payload_left == 0);
        if (pend) scan_phase = SCAN_TAG;
      end
      default: ;
    endcase

    // A message that stops inside a field reports truncation instead of
    // whatever this byte would have produced.
    if (last) begin
      mid = (scan_phase == SCAN_TAG) ? (varint_bytes != 0) : (scan_phase != SCAN_CORRUPT);
      if (mid) begin
        emit  = 1'b1;
        kind  = TK_TRUNCATED;
        value = '0;
        pbyte = '0;
        pend  = 1'b0;
        if (scan_phase == SCAN_TAG) begin
          cur_field = '0;
          cur_wire  = '0;
        end
      end
    end

    tok = '{token_kind: kind, field_id: cur_field, wire_code: cur_wire,
            field_value: value, payload_byte: pbyte, payload_end: pend,
            message_end: last};
    if (last) clear_scanner();
    return emit;
  endfunction

  function automatic dir_row_t plain_row(input logic [7:0] d, input bit l);
    return '{data: d, last: l, typed: 1'b0, has_tok: 1'b0, tok: '0};
  endfunction

  function automatic dir_row_t typed_row(input logic [7:0] d, input bit l, input bit has,
                                         input token_kind_e kind, input logic [28:0] fnum,
                                         input logic [2:0] wt, input logic [63:0] value);
    pws_out_t t;
    t = '{token_kind: kind, field_id: fnum, wire_code: wt, field_value: value,
          payload_byte: '0, payload_end: 1'b0, message_end: l};
    return '{data: d, last: l, typed: 1'b1, has_tok: has, tok: t};
  endfunction

  function automatic void put_varint(input logic [63:0] v);
    do begin
      msg_bytes.push_back({(v >> 7) != 0, v[6:0]});
      v = v >> 7;
    end while (v != 0);
  endfunction

  // Writes a tag; the field number is mostly small, sometimes at the top of
  // its range or wider than 29 bits so that the high bits get dropped.
  function automatic void put_tag(input logic [2:0] wt);
    logic [63:0] fnum;
    case ($urandom_range(0, 9))
      0:       fnum = 64'h1FFF_FFFF;
      1:       fnum = {$urandom, $urandom} >> 4;
      2:       fnum = 64'($urandom_range(0, 32'h1FFF_FFFF));
      default: fnum = 64'($urandom_range(0, 15));
    endcase
    put_varint((fnum << 3) | 64'(wt));
  endfunction

  // Mostly values below 2^63 spread over all sizes; now and then a full
  // 64-bit one, whose tenth byte overruns the varint limit.
  function automatic logic [63:0] rand_value();
    logic [63:0] v;
    v = {$urandom, $urandom};
    return ($urandom_range(0, 7) == 0) ? v : v >> $urandom_range(1, 64);
  endfunction

  // Presents one byte and returns at the edge where the transaction is taken.
  // Valid stays high afterwards so that a back-to-back byte needs no toggle.
  task automatic offer_byte(input logic [7:0] data, input bit last);
    int unsigned gap;
    gap = tx_idle ? $urandom_range(0, 13) : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= '{in_byte: data, last_byte: last};
    do @(posedge clk_i); while (in_stall_o);
  endtask

  // Receiver: a random stall before every token, with stretches of none, and
  // one long hold-off on request so that the block backs up into its input.
  initial begin : token_sink
    int unsigned hold;
    out_stall_i <= 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      if (long_hold_req) begin
        out_stall_i <= 1'b1;
        repeat (LONG_HOLD_CYCLES) @(posedge clk_i);
        long_hold_req = 1'b0;
      end
      if ($urandom_range(0, 31) == 0) rx_idle = !rx_idle;
      hold = rx_idle ? $urandom_range(0, 13) : 0;
      if (hold > 0) begin
        out_stall_i <= 1'b1;
        repeat (hold) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  always @(posedge clk_i) begin : token_check
    pws_out_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_tokens.size() == 0) begin
        $error("token with none expected: kind %0d field %0d value %0h",
               out_data_o.token_kind, out_data_o.field_id, out_data_o.field_value);
        mismatch_count++;
      end else begin
        want = expected_tokens.pop_front();
        if (out_data_o.token_kind !== want.token_kind) begin
          $error("token_kind: expected %0d, got %0d", want.token_kind,
                 out_data_o.token_kind);
          mismatch_count++;
        end
        if (out_data_o.field_id !== want.field_id) begin
          $error("field_id: expected %0d, got %0d", want.field_id,
                 out_data_o.field_id);
          mismatch_count++;
        end
        if (out_data_o.wire_code !== want.wire_code) begin
          $error("wire_code: expected %0d, got %0d", want.wire_code, out_data_o.wire_code);
          mismatch_count++;
        end
        if (out_data_o.field_value !== want.field_value) begin
          $error("field_value: expected %0h, got %0h", want.field_value,
                 out_data_o.field_value);
          mismatch_count++;
        end
        if (out_data_o.payload_byte !== want.payload_byte) begin
          $error("payload_byte: expected %0h, got %0h", want.payload_byte,
                 out_data_o.payload_byte);
          mismatch_count++;
        end
        if (out_data_o.payload_end !== want.payload_end) begin
          $error("payload_end: expected %0b, got %0b", want.payload_end,
                 out_data_o.payload_end);
          mismatch_count++;
        end
        if (out_data_o.message_end !== want.message_end) begin
          $error("message_end: expected %0b, got %0b", want.message_end,
                 out_data_o.message_end);
          mismatch_count++;
        end
      end
    end
  end

  initial begin : stimulus
    pws_out_t    tok;
    bit          emit;
    bit          counted;
    bit          hold_done;
    bit          pause_done;
    bit          msg_done;
    int unsigned quiet_msgs;
    int unsigned n_fields;
    int unsigned sel;
    int unsigned len;
    logic [2:0]  wt;

    hold_done  = 1'b0;
    pause_done = 1'b0;
    quiet_msgs = 0;
    clear_scanner();
    in_valid_i <= 1'b0;
    in_data_i  <= '0;
    rst_ni     <= 1'b0;

    // Message one: a two-byte payload, an empty payload, a fixed32, a skipped
    // 64-bit field, then a reserved wire type that swallows the rest.
    dir_table.push_back(plain_row(8'h12, 1'b0));
    dir_table.push_back(typed_row(8'h02, 1'b0, 1'b1, TK_LENGTH, 29'd2, WT_LEN, 64'd2));
    dir_table.push_back(plain_row(8'h00, 1'b0));
    dir_table.push_back(plain_row(8'hFF, 1'b0));
    dir_table.push_back(plain_row(8'h1A, 1'b0));
    dir_table.push_back(plain_row(8'h00, 1'b0));
    dir_table.push_back(plain_row(8'h25, 1'b0));
    dir_table.push_back(plain_row(8'h01, 1'b0));
    dir_table.push_back(plain_row(8'h80, 1'b0));
    dir_table.push_back(plain_row(8'h7F, 1'b0));
    dir_table.push_back(plain_row(8'hFF, 1'b0));
    dir_table.push_back(plain_row(8'h19, 1'b0));
    repeat (4) begin
      dir_table.push_back(plain_row(8'hFF, 1'b0));
      dir_table.push_back(plain_row(8'h00, 1'b0));
    end
    dir_table.push_back(typed_row(8'h0F, 1'b0, 1'b1, TK_CORRUPT, 29'd1, WT_RES7, '0));
    dir_table.push_back(typed_row(8'h42, 1'b1, 1'b0, TK_VARINT, '0, '0, '0));
    // Message two: a tag that never ends reads as field zero with a varint
    // after it, and that varint closes the message cleanly.
    repeat (MAX_VARINT_BYTES) dir_table.push_back(plain_row(8'h80, 1'b0));
    dir_table.push_back(typed_row(8'h7F, 1'b1, 1'b1, TK_VARINT, '0, WT_VARINT, 64'd127));
    // Messages that stop inside an unfinished tag and right after a tag.
    dir_table.push_back(typed_row(8'hFF, 1'b1, 1'b1, TK_TRUNCATED, '0, '0, '0));
    dir_table.push_back(typed_row(8'h08, 1'b1, 1'b1, TK_TRUNCATED, 29'd1, WT_VARINT, '0));

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_table[i]) begin
      offer_byte(dir_table[i].data, dir_table[i].last);
      emit = predict_token(dir_table[i].data, dir_table[i].last, tok);
      if (dir_table[i].typed) begin
        if (dir_table[i].has_tok) expected_tokens.push_back(dir_table[i].tok);
      end else if (emit) begin
        expected_tokens.push_back(tok);
      end
    end

    while (random_items < RANDOM_ITEMS) begin
      if (!hold_done && random_items >= RANDOM_ITEMS / 3) begin
        // Keep the input busy while the receiver holds off for a long time.
        hold_done = 1'b1;
        long_hold_req = 1'b1;
        tx_idle = 1'b0;
        quiet_msgs = 4;
      end else if (quiet_msgs > 0) begin
        quiet_msgs--;
      end else begin
        tx_idle = ($urandom_range(0, 3) != 0);
      end

      if (!pause_done && random_items >= 2 * RANDOM_ITEMS / 3) begin
        // Let the block run completely dry before going on.
        pause_done = 1'b1;
        in_valid_i <= 1'b0;
        @(posedge clk_i);
        wait (expected_tokens.size() == 0);
      end

      // Build one message: mostly well-formed fields with random content, with
      // runaway varints, reserved wire types, noise and early cuts mixed in.
      msg_bytes.delete();
      n_fields = $urandom_range(1, 6);
      msg_done = 1'b0;
      while (n_fields > 0 && !msg_done) begin
        n_fields--;
        sel = $urandom_range(0, 99);
        if (sel < 25) begin
          put_tag(WT_VARINT);
          put_varint(rand_value());
        end else if (sel < 38) begin
          put_tag(WT_I32);
          repeat (FIXED32_BYTES) msg_bytes.push_back(8'($urandom));
        end else if (sel < 48) begin
          put_tag(WT_I64);
          repeat (SKIP64_BYTES) msg_bytes.push_back(8'($urandom));
        end else if (sel < 73) begin
          len = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 20) : $urandom_range(0, 6);
          put_tag(WT_LEN);
          put_varint(64'(len));
          repeat (len) msg_bytes.push_back(8'($urandom));
        end else if (sel < 80) begin
          // A varint that never ends, either as the tag or as the value.
          if ($urandom_range(0, 1) == 0) begin
            repeat (MAX_VARINT_BYTES) msg_bytes.push_back(8'h80 | 8'($urandom_range(0, 127)));
            put_varint(rand_value());
          end else begin
            put_tag(WT_VARINT);
            repeat (MAX_VARINT_BYTES) msg_bytes.push_back(8'h80 | 8'($urandom_range(0, 127)));
          end
        end else if (sel < 86) begin
          case ($urandom_range(0, 3))
            0:       wt = WT_SGROUP;
            1:       wt = WT_EGROUP;
            2:       wt = WT_RES6;
            default: wt = WT_RES7;
          endcase
          put_tag(wt);
          repeat ($urandom_range(0, 5)) msg_bytes.push_back(8'($urandom));
          msg_done = 1'b1;
        end else begin
          repeat ($urandom_range(1, 4)) msg_bytes.push_back(8'($urandom));
        end
      end
      // Some messages end before their last field is complete.
      if ($urandom_range(0, 7) == 0 && msg_bytes.size() > 1)
        repeat ($urandom_range(1, msg_bytes.size() - 1)) void'(msg_bytes.pop_back());

      foreach (msg_bytes[i]) begin
        counted = (scan_phase != SCAN_CORRUPT);
        offer_byte(msg_bytes[i], i == msg_bytes.size() - 1);
        if (predict_token(msg_bytes[i], i == msg_bytes.size() - 1, tok))
          expected_tokens.push_back(tok);
        if (counted) random_items++;
      end
    end

    in_valid_i <= 1'b0;
    wait (expected_tokens.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("tb_protobuf_wire_scanner_core: done, clean");
    end else begin
      $display("tb_protobuf_wire_scanner_core: done, errors");
    end
    $finish;
  end

  initial begin : watchdog
    #3_000_000;
    $display("tb_protobuf_wire_scanner_core: done, errors");
    $finish;
  end

endmodule
